FILE: rtl/sm83alu_pkg.sv
package sm83alu_pkg;

  localparam int OpW = 6;
  localparam int DataW = 16;
  localparam int FlagW = 4;
  localparam int BitIdxW = 3;

  localparam logic [OpW-1:0] OP_ADD8 = 6'd0;
  localparam logic [OpW-1:0] OP_ADC = 6'd1;
  localparam logic [OpW-1:0] OP_SUB = 6'd2;
  localparam logic [OpW-1:0] OP_SBC = 6'd3;
  localparam logic [OpW-1:0] OP_AND = 6'd4;
  localparam logic [OpW-1:0] OP_XOR = 6'd5;
  localparam logic [OpW-1:0] OP_OR = 6'd6;
  localparam logic [OpW-1:0] OP_CP = 6'd7;
  localparam logic [OpW-1:0] OP_INC8 = 6'd8;
  localparam logic [OpW-1:0] OP_DEC8 = 6'd9;
  localparam logic [OpW-1:0] OP_INC16 = 6'd10;
  localparam logic [OpW-1:0] OP_DEC16 = 6'd11;
  localparam logic [OpW-1:0] OP_ADD16 = 6'd12;
  localparam logic [OpW-1:0] OP_ADD_SP = 6'd13;
  localparam logic [OpW-1:0] OP_DAA = 6'd14;
  localparam logic [OpW-1:0] OP_CPL = 6'd15;
  localparam logic [OpW-1:0] OP_SCF = 6'd16;
  localparam logic [OpW-1:0] OP_CCF = 6'd17;
  localparam logic [OpW-1:0] OP_RLCA = 6'd18;
  localparam logic [OpW-1:0] OP_RRCA = 6'd19;
  localparam logic [OpW-1:0] OP_RLA = 6'd20;
  localparam logic [OpW-1:0] OP_RRA = 6'd21;
  localparam logic [OpW-1:0] OP_RLC = 6'd22;
  localparam logic [OpW-1:0] OP_RRC = 6'd23;
  localparam logic [OpW-1:0] OP_RL = 6'd24;
  localparam logic [OpW-1:0] OP_RR = 6'd25;
  localparam logic [OpW-1:0] OP_SLA = 6'd26;
  localparam logic [OpW-1:0] OP_SRA = 6'd27;
  localparam logic [OpW-1:0] OP_SWAP = 6'd28;
  localparam logic [OpW-1:0] OP_SRL = 6'd29;
  localparam logic [OpW-1:0] OP_BIT = 6'd30;
  localparam logic [OpW-1:0] OP_RES = 6'd31;
  localparam logic [OpW-1:0] OP_SET = 6'd32;

  localparam int FZ = 3;
  localparam int FN = 2;
  localparam int FH = 1;
  localparam int FC = 0;

endpackage

FILE: rtl/sm83_alu_with_flags_unit.sv
// SM83 arithmetic and logic unit with flag generation.
// The input channel (in_valid, in_stall) carries one word per operation:
// operation, operand_a, operand_b, bit_index and flags_in (Z, N, H, C in
// bits 3 down to 0). The output channel (out_valid, out_stall) returns one
// word per input word: result_value, flags_out and writes_result.
// A word is taken into an input register, the whole operation is computed
// by adders and multiplexers between that register and the result
// register, which loads the result while it is empty or not stalled.
// One word is accepted every cycle while the output is not stalled.
// When the receiver stalls, the result register holds its word and the
// input register can still take one more word; in_stall rises only when
// both registers are full and the output is stalled.
// Reset clears both valid flags; no word is in flight after reset.
module sm83_alu_with_flags_unit
  import sm83alu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OpW-1:0]     operation,
  input  logic [DataW-1:0]   operand_a,
  input  logic [DataW-1:0]   operand_b,
  input  logic [BitIdxW-1:0] bit_index,
  input  logic [FlagW-1:0]   flags_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DataW-1:0]   result_value,
  output logic [FlagW-1:0]   flags_out,
  output logic               writes_result
);

  logic               s1_valid;
  logic [OpW-1:0]     s1_op;
  logic [DataW-1:0]   s1_a16;
  logic [DataW-1:0]   s1_b16;
  logic [BitIdxW-1:0] s1_bi;
  logic [FlagW-1:0]   s1_fin;

  logic s1_advance;
  logic s2_load;

  logic [7:0]       a;
  logic [7:0]       b;
  logic             cin;
  logic             t;
  logic [8:0]       add9;
  logic [4:0]       addh;
  logic [7:0]       sub8;
  logic             sub_c;
  logic             sub_h;
  logic [7:0]       inc8;
  logic [7:0]       dec8;
  logic [16:0]      add17;
  logic [12:0]      add13;
  logic [DataW-1:0] sp_sum;
  logic [4:0]       sp_h;
  logic [8:0]       sp_c;
  logic [7:0]       daa_adj;
  logic             daa_c;
  logic [7:0]       daa_r;
  logic [7:0]       bit_mask;
  logic [7:0]       sh8;
  logic             sh_c;

  logic [DataW-1:0] r_next;
  logic [FlagW-1:0] f_next;
  logic             wr_next;

  assign s2_load = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && !s2_load;
  assign s1_advance = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_advance) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      s1_op  <= operation;
      s1_a16 <= operand_a;
      s1_b16 <= operand_b;
      s1_bi  <= bit_index;
      s1_fin <= flags_in;
    end
  end

  always_comb begin
    a = s1_a16[7:0];
    b = s1_b16[7:0];
    cin = s1_fin[FC];
    t = (s1_op == OP_ADC || s1_op == OP_SBC) ? cin : 1'b0;

    add9 = {1'b0, a} + {1'b0, b} + {8'd0, t};
    addh = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};

    sub8 = a - b - {7'd0, t};
    sub_c = {1'b0, a} < ({1'b0, b} + {8'd0, t});
    sub_h = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'd0, t});

    inc8 = a + 8'd1;
    dec8 = a - 8'd1;

    add17 = {1'b0, s1_a16} + {1'b0, s1_b16};
    add13 = {1'b0, s1_a16[11:0]} + {1'b0, s1_b16[11:0]};

    sp_sum = s1_a16 + {{8{b[7]}}, b};
    sp_h = {1'b0, s1_a16[3:0]} + {1'b0, b[3:0]};
    sp_c = {1'b0, s1_a16[7:0]} + {1'b0, b};

    daa_adj = 8'h00;
    daa_c = 1'b0;
    if (s1_fin[FH] || (!s1_fin[FN] && a[3:0] > 4'd9)) begin
      daa_adj = 8'h06;
    end
    if (cin || (!s1_fin[FN] && a > 8'h99)) begin
      daa_adj = daa_adj | 8'h60;
      daa_c = 1'b1;
    end
    daa_r = s1_fin[FN] ? (a - daa_adj) : (a + daa_adj);

    bit_mask = 8'd1 << s1_bi;

    sh8 = 8'h00;
    sh_c = 1'b0;
    case (s1_op) inside
      OP_RLCA, OP_RLC: begin
        sh8 = {a[6:0], a[7]};
        sh_c = a[7];
      end
      OP_RRCA, OP_RRC: begin
        sh8 = {a[0], a[7:1]};
        sh_c = a[0];
      end
      OP_RLA, OP_RL: begin
        sh8 = {a[6:0], cin};
        sh_c = a[7];
      end
      OP_RRA, OP_RR: begin
        sh8 = {cin, a[7:1]};
        sh_c = a[0];
      end
      OP_SLA: begin
        sh8 = {a[6:0], 1'b0};
        sh_c = a[7];
      end
      OP_SRA: begin
        sh8 = {a[7], a[7:1]};
        sh_c = a[0];
      end
      OP_SWAP: begin
        sh8 = {a[3:0], a[7:4]};
        sh_c = 1'b0;
      end
      OP_SRL: begin
        sh8 = {1'b0, a[7:1]};
        sh_c = a[0];
      end
      default: begin
        sh8 = 8'h00;
        sh_c = 1'b0;
      end
    endcase

    r_next = '0;
    f_next = s1_fin;
    wr_next = 1'b1;
    unique case (s1_op) inside
      OP_ADD8, OP_ADC: begin
        r_next = {8'd0, add9[7:0]};
        f_next = {add9[7:0] == 8'd0, 1'b0, addh[4], add9[8]};
      end
      OP_SUB, OP_SBC: begin
        r_next = {8'd0, sub8};
        f_next = {sub8 == 8'd0, 1'b1, sub_h, sub_c};
      end
      OP_CP: begin
        f_next = {sub8 == 8'd0, 1'b1, sub_h, sub_c};
        wr_next = 1'b0;
      end
      OP_AND: begin
        r_next = {8'd0, a & b};
        f_next = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        r_next = {8'd0, a ^ b};
        f_next = {(a ^ b) == 8'd0, 3'b000};
      end
      OP_OR: begin
        r_next = {8'd0, a | b};
        f_next = {(a | b) == 8'd0, 3'b000};
      end
      OP_INC8: begin
        r_next = {8'd0, inc8};
        f_next = {inc8 == 8'd0, 1'b0, inc8[3:0] == 4'h0, cin};
      end
      OP_DEC8: begin
        r_next = {8'd0, dec8};
        f_next = {dec8 == 8'd0, 1'b1, dec8[3:0] == 4'hF, cin};
      end
      OP_INC16: begin
        r_next = s1_a16 + 16'd1;
      end
      OP_DEC16: begin
        r_next = s1_a16 - 16'd1;
      end
      OP_ADD16: begin
        r_next = add17[15:0];
        f_next = {s1_fin[FZ], 1'b0, add13[12], add17[16]};
      end
      OP_ADD_SP: begin
        r_next = sp_sum;
        f_next = {2'b00, sp_h[4], sp_c[8]};
      end
      OP_DAA: begin
        r_next = {8'd0, daa_r};
        f_next = {daa_r == 8'd0, s1_fin[FN], 1'b0, daa_c};
      end
      OP_CPL: begin
        r_next = {8'd0, ~a};
        f_next = {s1_fin[FZ], 1'b1, 1'b1, cin};
      end
      OP_SCF: begin
        f_next = {s1_fin[FZ], 2'b00, 1'b1};
        wr_next = 1'b0;
      end
      OP_CCF: begin
        f_next = {s1_fin[FZ], 2'b00, ~cin};
        wr_next = 1'b0;
      end
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        r_next = {8'd0, sh8};
        f_next = {3'b000, sh_c};
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
        r_next = {8'd0, sh8};
        f_next = {sh8 == 8'd0, 2'b00, sh_c};
      end
      OP_BIT: begin
        f_next = {(a & bit_mask) == 8'd0, 1'b0, 1'b1, cin};
        wr_next = 1'b0;
      end
      OP_RES: begin
        r_next = {8'd0, a & ~bit_mask};
      end
      OP_SET: begin
        r_next = {8'd0, a | bit_mask};
      end
      default: begin
        wr_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      result_value  <= r_next;
      flags_out     <= f_next;
      writes_result <= wr_next;
    end
  end

endmodule
